/* rtl/core/b64se_pkg.sv */
`default_nettype none

package b64se_pkg;

  // Payload of one input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Payload of one output request.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  // One group of up to three bytes handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] real_cnt;  // number of real bytes, 1 to 3
    logic       fin;       // group closes the message
  } group_t;

  // Queue between front and back end.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Character constants.
  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
  localparam logic [7:0] CharSlash = 8'h2f;  // '/'
  localparam logic [7:0] CharDash  = 8'h2d;  // '-'
  localparam logic [7:0] CharUnder = 8'h5f;  // '_'
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharLoA   = 8'h61;  // 'a'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'

  // Map a sextet to its base64 character in the chosen alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url_safe);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      c = CharUpA + v8;
    end else if (v < 6'd52) begin
      c = CharLoA + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      c = CharZero + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      c = url_safe ? CharDash : CharPlus;
    end else begin
      c = url_safe ? CharUnder : CharSlash;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/b64se_front.sv */
`default_nettype none

module b64se_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire b64se_pkg::in_t    in_data,
  output logic                   push,
  output b64se_pkg::group_t      push_group,
  input  wire logic              q_full
);

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] pend0_r, pend1_r;
  logic       accept;

  // Take a byte whenever the queue can hold a group that it might close.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_data.last_byte || (pos_r == 2'd2));

  // Assemble the group from held bytes and the incoming byte.
  always_comb begin
    push_group.b0       = (pos_r == 2'd0) ? in_data.data_byte : pend0_r;
    push_group.b1       = (pos_r == 2'd1) ? in_data.data_byte :
                          (pos_r == 2'd2) ? pend1_r : 8'd0;
    push_group.b2       = (pos_r == 2'd2) ? in_data.data_byte : 8'd0;
    push_group.real_cnt = pos_r + 2'd1;
    push_group.fin      = in_data.last_byte;
  end

  // Position within the three-byte group.
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = push ? 2'd0 : pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Held bytes need no reset; they are read only after being written.
  always_ff @(posedge clk) begin
    if (accept && !push) begin
      if (pos_r == 2'd0) begin
        pend0_r <= in_data.data_byte;
      end else begin
        pend1_r <= in_data.data_byte;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/b64se_queue.sv */
`default_nettype none

module b64se_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire b64se_pkg::group_t push_group,
  output logic                   full,
  input  wire logic              pop,
  output b64se_pkg::group_t      pop_group,
  output logic                   empty
);

  b64se_pkg::group_t                mem_r [b64se_pkg::QueueDepth];
  logic [b64se_pkg::QPtrW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [b64se_pkg::QCntW-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full      = (cnt_r == b64se_pkg::QCntW'(b64se_pkg::QueueDepth));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_group = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == b64se_pkg::QPtrW'(b64se_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == b64se_pkg::QPtrW'(b64se_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_group;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/b64se_back.sv */
`default_nettype none

module b64se_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              url_safe,
  output logic                   pop,
  input  wire b64se_pkg::group_t pop_group,
  input  wire logic              q_empty,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output b64se_pkg::out_t        out_data
);

  b64se_pkg::group_t grp_r;
  logic              busy_r, busy_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  b64se_pkg::out_t   out_data_r;
  logic              issue;
  logic              load;
  logic [5:0]        sextet;
  b64se_pkg::out_t   chr;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A character goes out when the output register is free or being drained.
  assign issue = busy_r && (!out_valid_r || out_ready);
  assign load  = !q_empty && (!busy_r || (issue && (idx_r == 2'd3)));
  assign pop   = load;

  // Pick the sextet for the current character position.
  always_comb begin
    case (idx_r)
      2'd0:    sextet = grp_r.b0[7:2];
      2'd1:    sextet = {grp_r.b0[1:0], grp_r.b1[7:4]};
      2'd2:    sextet = {grp_r.b1[3:0], grp_r.b2[7:6]};
      default: sextet = grp_r.b2[5:0];
    endcase
  end

  // Positions past the real bytes become padding.
  always_comb begin
    chr.out_char  = (idx_r <= grp_r.real_cnt) ?
                    b64se_pkg::sextet_char(sextet, url_safe) : b64se_pkg::CharPad;
    chr.last_char = grp_r.fin && (idx_r == 2'd3);
  end

  // Sequencing of the four characters of a group.
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= pop_group;
    end
    if (issue) begin
      out_data_r <= chr;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/base64_stream_encoder_top.sv */
`default_nettype none

// Base64 (RFC 4648) stream encoder. Raw bytes enter one per request on the
// in_ channel, the final byte of a message flagged by last_byte; ASCII
// characters leave one per request on the out_ channel, the final character
// of a message flagged by last_char. A partial final group is zero-filled and
// padded with '=' to four characters; an empty message yields nothing. The
// front end takes one byte per cycle while its two-entry group queue has room,
// and the back end sends one character per cycle from its output register while
// out_ready is high, so the single-character output register, which sends four
// characters per group, sets sustained throughput. Writing 1 to cfg_data
// selects the URL-safe alphabet ('-' and '_' for '+' and '/'); write it only
// while the encoder is idle. cfg_ready is always high.
module base64_stream_encoder_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire b64se_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output b64se_pkg::out_t        out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  logic              url_safe_r;
  logic              push, pop, q_full, q_empty;
  b64se_pkg::group_t push_group, pop_group;

  // Alphabet select register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_safe_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      url_safe_r <= cfg_data;
    end
  end

  // Front end: gathers bytes into groups.
  b64se_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_group (push_group),
    .q_full     (q_full)
  );

  // Group queue between the two ends.
  b64se_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .pop_group  (pop_group),
    .empty      (q_empty)
  );

  // Back end: serializes characters.
  b64se_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .url_safe   (url_safe_r),
    .pop        (pop),
    .pop_group  (pop_group),
    .q_empty    (q_empty),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
